FILE: rtl/core/actuator_slew_lag_second_order_assert.svh
// Assertion macros for the block's RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ACTUATOR_SLEW_LAG_SECOND_ORDER_ASSERT_SVH
`define ACTUATOR_SLEW_LAG_SECOND_ORDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASLSO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aslso: same-cycle check failed");
`define ASLSO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aslso: next-cycle check failed");
`else
`define ASLSO_ASSERT_IMP(lbl, ante, cons)
`define ASLSO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/aslso_pkg.sv
package aslso_pkg;

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned DT_W    = 25;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SLEW_W  = 32;
  localparam int unsigned LAG_W   = 30;
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned ZETA_W  = 20;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ST_W    = 5;

  localparam int unsigned SUBSTEP_RATE_DEF    = 240;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_SLEW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LAG    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_SLEW = 3'd1;
  localparam logic [2:0] REG_LAG  = 3'd2;
  localparam logic [2:0] REG_FREQ = 3'd3;
  localparam logic [2:0] REG_ZETA = 3'd4;

  localparam logic [MODE_W-1:0] MODE_RST = 2'd0;
  localparam logic [SLEW_W-1:0] SLEW_RST = 32'd3932160;
  localparam logic [LAG_W-1:0]  LAG_RST  = 30'd655360;
  localparam logic [FREQ_W-1:0] FREQ_RST = 24'd327680;
  localparam logic [ZETA_W-1:0] ZETA_RST = 20'd65536;

  localparam logic [DT_W-1:0]   DT_ONE     = 25'h1000000;
  localparam logic [FREQ_W-1:0] FREQ_MIN   = 24'd7;
  localparam logic [31:0]       TWO_PI_Q29 = 32'd3373259426;

  // one request to the shared multiply unit
  typedef struct packed {
    logic [62:0]     a_mag;
    logic            a_neg;
    logic [47:0]     b;
    logic [5:0]      sh;
    logic [ST_W-1:0] ret;
  } mul_req_t;

endpackage

FILE: rtl/core/aslso_stream_if.sv
interface aslso_in_if;
  import aslso_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [ANGLE_W-1:0]  angle_in;
  logic        [DT_W-1:0]     delta_time;
  modport source (output valid, action, angle_in, delta_time, input ready);
  modport sink   (input valid, action, angle_in, delta_time, output ready);
endinterface

interface aslso_out_if;
  import aslso_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  angle_out;
  logic signed [ANGLE_W-1:0]  velocity_out;
  modport source (output valid, angle_out, velocity_out, input ready);
  modport sink   (input valid, angle_out, velocity_out, output ready);
endinterface

FILE: rtl/core/actuator_slew_lag_second_order.sv
`include "actuator_slew_lag_second_order_assert.svh"

// Actuator angle model: one request in, one result out.
// Input channel in_i carries action, angle_in (Q16.16 deg) and delta_time
// (Q1.24 s). Output channel out_o carries angle_out and velocity_out.
// The APB port writes and reads the five model registers at 4*index.
// A load request or a zero time step goes straight to the result register.
// Mode 0 runs one multiply, mode 1 up to three. Mode 2 runs a setup of four
// multiplies and a restoring divider, then ceil(dt*SUBSTEP_RATE) substeps
// of four multiplies each, 240 substeps for a full one-second step by default.
// The cost is set by the single 32x32 multiplier, which runs every product
// as four partial products, then accumulates and saturates.
// One request is in work at a time; in_i.ready is high while idle.
// The finished result sits in an output register, so a new request is
// taken while the receiver stalls; the next result waits for that register.
// Reset clears angle and velocity to zero and loads the register defaults.
module actuator_slew_lag_second_order #(
  parameter int unsigned SUBSTEP_RATE    = aslso_pkg::SUBSTEP_RATE_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = aslso_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aslso_pkg::ADDR_W-1:0] paddr,
  input  logic [aslso_pkg::DATA_W-1:0] pwdata,
  output logic [aslso_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  aslso_in_if.sink                     in_i,
  aslso_out_if.source                  out_o
);
  import aslso_pkg::*;

  localparam int unsigned NW = $clog2(SUBSTEP_RATE + 1);
  // smallest distance magnitude for which the lag factor applies
  localparam logic [63:0] LAG_MIN64 =
    ((64'd1 << ANGLE_FRAC_BITS) + 64'd9999) / 64'd10000;
  localparam logic [32:0] LAG_MIN = LAG_MIN64[32:0];
  localparam logic [5:0] DIV_LAST = 6'd32;
  localparam logic [24:0] DT_DONE_FAC = 25'h1000000;

  localparam logic [5:0] SH_TZO   = 6'd11;
  localparam logic [5:0] SH_LAGF  = 6'd16;
  localparam logic [5:0] SH_Q24   = 6'd24;
  localparam logic [5:0] SH_OMEGA = 6'd25;
  localparam logic [5:0] SH_Q32   = 6'd32;

  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_MUL   = 5'd1;
  localparam logic [ST_W-1:0] S_SLEW  = 5'd2;
  localparam logic [ST_W-1:0] S_FAC   = 5'd3;
  localparam logic [ST_W-1:0] S_LAG   = 5'd4;
  localparam logic [ST_W-1:0] S_OMEGA = 5'd5;
  localparam logic [ST_W-1:0] S_W2    = 5'd6;
  localparam logic [ST_W-1:0] S_TZO   = 5'd7;
  localparam logic [ST_W-1:0] S_DIV   = 5'd8;
  localparam logic [ST_W-1:0] S_SA    = 5'd9;
  localparam logic [ST_W-1:0] S_SB    = 5'd10;
  localparam logic [ST_W-1:0] S_SC    = 5'd11;
  localparam logic [ST_W-1:0] S_SD    = 5'd12;
  localparam logic [ST_W-1:0] S_SE    = 5'd13;
  localparam logic [ST_W-1:0] S_SF    = 5'd14;
  localparam logic [ST_W-1:0] S_OUT   = 5'd15;

  // model registers
  logic [MODE_W-1:0] mode_q;
  logic [SLEW_W-1:0] slew_q;
  logic [LAG_W-1:0]  lag_q;
  logic [FREQ_W-1:0] freq_q;
  logic [ZETA_W-1:0] zeta_q;

  // sequencer and datapath state
  logic [ST_W-1:0]           state_q;
  mul_req_t                  mreq_q;
  logic [2:0]                mcnt_q;
  logic [63:0]               prod_q;
  logic [111:0]              acc_q;
  logic signed [63:0]        mres_q;
  logic signed [ANGLE_W-1:0] tgt_q;
  logic signed [ANGLE_W-1:0] ang_q;
  logic signed [ANGLE_W-1:0] vel_q;
  logic [DT_W-1:0]           dt_q;
  logic [32:0]               maxstep_q;
  logic [30:0]               omega_q;
  logic [45:0]               w2_q;
  logic [39:0]               tzo_q;
  logic signed [63:0]        p1_q;
  logic [32:0]               quo_q;
  logic [NW-1:0]             rem_q;
  logic [NW-1:0]             n_q;
  logic [NW-1:0]             scnt_q;
  logic [5:0]                dcnt_q;
  logic                      out_valid_q;
  logic signed [ANGLE_W-1:0] out_ang_q;
  logic signed [ANGLE_W-1:0] out_vel_q;

  logic in_fire;
  logic cfg_wr;

  function automatic mul_req_t mul_req(input logic signed [63:0] a, input logic [47:0] b,
                                       input logic [5:0] sh, input logic [ST_W-1:0] ret);
    mul_req_t    r;
    logic [63:0] m;
    m       = a[63] ? 64'(-a) : 64'(a);
    r.a_mag = m[62:0];
    r.a_neg = a[63];
    r.b     = b;
    r.sh    = sh;
    r.ret   = ret;
    return r;
  endfunction

  // clamp a move to +-ms
  function automatic logic signed [63:0] clamp_ms(input logic signed [63:0] v,
                                                  input logic [32:0] ms);
    logic signed [63:0] lim;
    lim = $signed({31'b0, ms});
    if (v > lim) return lim;
    else if (v < -lim) return -lim;
    else return v;
  endfunction

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.angle_out    = out_ang_q;
  assign out_o.velocity_out = out_vel_q;

  // register read back
  always_comb begin
    case (paddr[4:2])
      REG_MODE: prdata = {30'b0, mode_q};
      REG_SLEW: prdata = slew_q;
      REG_LAG:  prdata = {2'b0, lag_q};
      REG_FREQ: prdata = {8'b0, freq_q};
      REG_ZETA: prdata = {12'b0, zeta_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
      slew_q <= SLEW_RST;
      lag_q  <= LAG_RST;
      freq_q <= FREQ_RST;
      zeta_q <= ZETA_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE: mode_q <= pwdata[MODE_W-1:0];
        REG_SLEW: slew_q <= pwdata[SLEW_W-1:0];
        REG_LAG:  lag_q  <= pwdata[LAG_W-1:0];
        REG_FREQ: freq_q <= pwdata[FREQ_W-1:0];
        REG_ZETA: zeta_q <= pwdata[ZETA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Combinational helpers around the registered state
  // ---------------------------------------------------------------
  logic [DT_W-1:0]    dt_sat;
  logic signed [32:0] dist_v;
  logic [32:0]        dist_mag;
  logic signed [63:0] dist64;
  logic signed [63:0] ang64;
  logic signed [63:0] vel64;
  logic [FREQ_W-1:0]  f_eff;
  logic [24:0]        fac;

  assign dt_sat   = (in_i.delta_time > DT_ONE) ? DT_ONE : in_i.delta_time;
  assign dist_v   = {tgt_q[31], tgt_q} - {ang_q[31], ang_q};
  assign dist_mag = dist_v[32] ? 33'(-dist_v) : 33'(dist_v);
  assign dist64   = {{31{dist_v[32]}}, dist_v};
  assign ang64    = {{32{ang_q[31]}}, ang_q};
  assign vel64    = {{32{vel_q[31]}}, vel_q};
  assign f_eff    = (freq_q < FREQ_MIN) ? FREQ_MIN : freq_q;
  assign fac      = (mres_q > 64'sd16777216) ? DT_DONE_FAC : mres_q[24:0];

  // slew-limited targets for modes 0 and 1
  logic signed [63:0] slew_sum;
  logic signed [63:0] lag_sum;
  assign slew_sum = ang64 + clamp_ms(dist64, mres_q[32:0]);
  assign lag_sum  = ang64 + clamp_ms(mres_q, maxstep_q);

  // velocity limits: +-max_slew_rate within the signed 32-bit range
  logic signed [63:0] vhi;
  logic signed [63:0] vlo;
  logic signed [63:0] v_sum;
  logic signed [63:0] v_clamp;
  logic signed [63:0] a_sum;
  logic signed [63:0] a_clamp;
  assign vhi = slew_q[31] ? 64'sh7FFFFFFF : $signed({32'b0, slew_q});
  assign vlo = (slew_q > 32'h80000000) ? -64'sh80000000 : -$signed({32'b0, slew_q});
  assign v_sum = vel64 + mres_q;
  assign v_clamp = (v_sum > vhi) ? vhi : ((v_sum < vlo) ? vlo : v_sum);
  assign a_sum = ang64 + mres_q;
  assign a_clamp = (a_sum > 64'sh7FFFFFFF) ? 64'sh7FFFFFFF :
                   ((a_sum < -64'sh80000000) ? -64'sh80000000 : a_sum);

  // substep count: ceil(dt * SUBSTEP_RATE / 2^24), at least one
  logic [DT_W+NW-1:0] n_prod;
  logic [DT_W+NW:0]   n_sum;
  logic [NW-1:0]      n_calc;
  assign n_prod = dt_q * NW'(SUBSTEP_RATE);
  assign n_sum  = {1'b0, n_prod} + (DT_W+NW+1)'(24'hFFFFFF);
  assign n_calc = (n_sum[24 +: NW] == '0) ? NW'(1) : n_sum[24 +: NW];

  // restoring divider step
  logic [NW:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, quo_q[32]};
  assign q_bit  = (rem_sh >= {1'b0, n_q});

  // multiply unit: partial-product operand select
  logic [1:0]   pair;
  logic [1:0]   prev;
  logic [31:0]  a_limb;
  logic [31:0]  b_limb;
  logic [111:0] pp_shift;
  assign pair   = mcnt_q[1:0];
  assign prev   = 2'(mcnt_q - 3'd1);
  assign a_limb = pair[1] ? {1'b0, mreq_q.a_mag[62:32]} : mreq_q.a_mag[31:0];
  assign b_limb = pair[0] ? {16'b0, mreq_q.b[47:32]} : mreq_q.b[31:0];
  always_comb begin
    case (prev)
      2'd0:    pp_shift = {48'b0, prod_q};
      2'd3:    pp_shift = {prod_q[47:0], 64'b0};
      default: pp_shift = {16'b0, prod_q, 32'b0};
    endcase
  end

  // shift, saturate to 2^61, restore sign
  logic [111:0]       shr;
  logic [61:0]        sat_mag;
  logic signed [63:0] sat_res;
  assign shr     = acc_q >> mreq_q.sh;
  assign sat_mag = (shr > (112'd1 << 61)) ? (62'd1 << 61) : shr[61:0];
  assign sat_res = mreq_q.a_neg ? -$signed({2'b0, sat_mag}) : $signed({2'b0, sat_mag});

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      ang_q       <= '0;
      vel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken; S_OUT refills the register itself
      if (out_o.valid && out_o.ready && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            tgt_q <= in_i.angle_in;
            dt_q  <= dt_sat;
            if (in_i.action) begin
              // load: new angle, velocity cleared
              ang_q   <= in_i.angle_in;
              vel_q   <= '0;
              state_q <= S_OUT;
            end else if (dt_sat == '0 ||
                         (mode_q != MODE_SLEW && mode_q != MODE_LAG &&
                          mode_q != MODE_SECOND)) begin
              state_q <= S_OUT;
            end else begin
              // slew step = max_slew_rate * dt >> 24
              mreq_q  <= mul_req({32'b0, slew_q}, {23'b0, dt_sat}, SH_Q24, S_SLEW);
              mcnt_q  <= '0;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mcnt_q < 3'd4) prod_q <= a_limb * b_limb;
          if (mcnt_q == 3'd0) acc_q <= '0;
          else if (mcnt_q <= 3'd4) acc_q <= acc_q + pp_shift;
          if (mcnt_q == 3'd5) begin
            mres_q  <= sat_res;
            state_q <= mreq_q.ret;
            mcnt_q  <= '0;
          end else begin
            mcnt_q <= mcnt_q + 3'd1;
          end
        end
        S_SLEW: begin
          maxstep_q <= mres_q[32:0];
          if (mode_q == MODE_SLEW) begin
            ang_q   <= slew_sum[31:0];
            vel_q   <= '0;
            state_q <= S_OUT;
          end else if (mode_q == MODE_LAG) begin
            vel_q <= '0;
            if (lag_q != '0 && dist_mag >= LAG_MIN) begin
              mreq_q  <= mul_req({39'b0, dt_q}, {18'b0, lag_q}, SH_LAGF, S_FAC);
              state_q <= S_MUL;
            end else begin
              // close distance or zero lag: jump, still slew limited
              ang_q   <= slew_sum[31:0];
              state_q <= S_OUT;
            end
          end else begin
            mreq_q  <= mul_req({40'b0, f_eff}, {16'b0, TWO_PI_Q29}, SH_OMEGA, S_OMEGA);
            state_q <= S_MUL;
          end
        end
        S_FAC: begin
          mreq_q  <= mul_req(dist64, {23'b0, fac}, SH_Q24, S_LAG);
          state_q <= S_MUL;
        end
        S_LAG: begin
          ang_q   <= lag_sum[31:0];
          state_q <= S_OUT;
        end
        S_OMEGA: begin
          omega_q <= mres_q[30:0];
          mreq_q  <= mul_req({33'b0, mres_q[30:0]}, {17'b0, mres_q[30:0]}, SH_LAGF, S_W2);
          state_q <= S_MUL;
        end
        S_W2: begin
          w2_q    <= mres_q[45:0];
          // 2*zeta*omega >> 12 equals zeta*omega >> 11
          mreq_q  <= mul_req({44'b0, zeta_q}, {17'b0, omega_q}, SH_TZO, S_TZO);
          state_q <= S_MUL;
        end
        S_TZO: begin
          tzo_q   <= mres_q[39:0];
          n_q     <= n_calc;
          quo_q   <= {dt_q, 8'b0};
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // substep time = (dt << 8) / n, one quotient bit per cycle
          rem_q  <= q_bit ? NW'(rem_sh - {1'b0, n_q}) : rem_sh[NW-1:0];
          quo_q  <= {quo_q[31:0], q_bit};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == DIV_LAST) begin
            scnt_q  <= n_q;
            state_q <= S_SA;
          end
        end
        S_SA: begin
          mreq_q  <= mul_req(dist64, {2'b0, w2_q}, SH_Q24, S_SB);
          state_q <= S_MUL;
        end
        S_SB: begin
          p1_q    <= mres_q;
          mreq_q  <= mul_req(vel64, {8'b0, tzo_q}, SH_Q24, S_SC);
          state_q <= S_MUL;
        end
        S_SC: begin
          mreq_q  <= mul_req(p1_q - mres_q, {15'b0, quo_q}, SH_Q32, S_SD);
          state_q <= S_MUL;
        end
        S_SD: begin
          vel_q   <= v_clamp[31:0];
          state_q <= S_SE;
        end
        S_SE: begin
          mreq_q  <= mul_req(vel64, {15'b0, quo_q}, SH_Q32, S_SF);
          state_q <= S_MUL;
        end
        S_SF: begin
          ang_q  <= a_clamp[31:0];
          scnt_q <= scnt_q - NW'(1);
          state_q <= (scnt_q == NW'(1)) ? S_OUT : S_SA;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_ang_q   <= ang_q;
            out_vel_q   <= vel_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASLSO_ASSERT_NXT(a_load_clears_vel, in_fire && in_i.action, state_q == S_OUT && vel_q == '0)
  `ASLSO_ASSERT_IMP(a_mul_count, state_q == S_MUL, mcnt_q <= 3'd5)
  `ASLSO_ASSERT_IMP(a_substep_left, state_q == S_SA, scnt_q != '0)
  `ASLSO_ASSERT_IMP(a_vel_limit, state_q == S_SF, vel64 <= vhi && vel64 >= vlo)

endmodule
